[hw/rtl/trz_pkg.sv]
// Shared types, constants and configuration codes of the tile rotate and zoom block.
// No dependencies; every other file of the block imports this package.
package trz_pkg;

  localparam int unsigned COORD_W    = 5;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 6;
  localparam int unsigned TURNS_W    = 2;
  localparam int unsigned ZOOM_W     = 12;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned MAX_DIM     = 32;
  localparam int unsigned STORE_SIDE  = 32;
  localparam int unsigned STORE_DEPTH = STORE_SIDE * STORE_SIDE;
  localparam int unsigned ADDR_W      = 2 * COORD_W;

  // Restoring divider: one quotient bit per stage.
  localparam int unsigned DIV_STEPS = COORD_W;
  localparam int unsigned REM_W     = COORD_W + FRAC_W;
  localparam int unsigned DIVR_W    = ZOOM_W + DIV_STEPS - 1;

  localparam int unsigned MID_DEPTH  = 2;
  localparam int unsigned MID_AW     = 1;
  localparam int unsigned MID_CNT_W  = 2;
  localparam int unsigned OUTQ_DEPTH = 16;
  localparam int unsigned OUTQ_AW    = 4;
  localparam int unsigned OUTQ_CNT_W = 5;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_READ = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE     = 2'd0,
    CFG_QUARTER_TURNS = 2'd1,
    CFG_ZOOM_Q8       = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel_out;
    logic              in_range;
    logic [SIZE_W-1:0] out_size;
  } res_item_t;

  // Effective configuration, derived once in the top level.
  typedef struct packed {
    logic [COORD_W-1:0] last_idx;
    logic [ZOOM_W-1:0]  zoom;
    logic [TURNS_W-1:0] turns;
    logic [SIZE_W-1:0]  out_size;
  } cfg_t;

  // Classified item between front and back.
  typedef struct packed {
    req_type_e          req_type;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [PIX_W-1:0]   pixel;
    logic               ovf_r;
    logic               ovf_c;
    logic               in_range;
    logic [SIZE_W-1:0]  out_size;
  } mid_item_t;

endpackage

[hw/rtl/tile_rotate_and_nearest_zoom_top.sv]
// Tile rotate and nearest zoom, top level. Throughput: one item per cycle, but reads stall
// while the result queue has no free credit. A read item passes the mid queue, five divider
// stages, the mapping stage and the store read into the result queue.
// Loads produce no result; they write the store at the stage where reads read it.
// Reset (rst_ni low, async): queues and pipeline empty, tile_size 32,
// quarter_turns 0, zoom_q8 256. The pixel store is not cleared.
module tile_rotate_and_nearest_zoom_top import trz_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // item input
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  // result output
  output logic                  empty,
  input  logic                  pop,
  output res_item_t             res_item_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned PROD_W     = SIZE_W + ZOOM_W;
  localparam int unsigned RAW_W      = PROD_W - FRAC_W;
  localparam int unsigned ROUND_HALF = 1 << (FRAC_W - 1);

  logic [SIZE_W-1:0]  tile_size_q;
  logic [TURNS_W-1:0] quarter_turns_q;
  logic [ZOOM_W-1:0]  zoom_q8_q;

  logic [SIZE_W-1:0]  n_eff;
  logic [ZOOM_W-1:0]  z_eff;
  logic [PROD_W-1:0]  prod;
  logic [RAW_W-1:0]   size_raw;
  cfg_t               cfg;

  mid_item_t          mid_head;
  logic               mid_vld;
  logic               mid_pop;
  logic               res_push;
  res_item_t          res_item;
  logic               out_pop;
  logic               outq_full;

  // Config registers; an index past the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q     <= SIZE_W'(STORE_SIDE);
      quarter_turns_q <= '0;
      zoom_q8_q       <= ZOOM_W'(1 << FRAC_W);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TILE_SIZE:     tile_size_q     <= cfg_data_i[SIZE_W-1:0];
        CFG_QUARTER_TURNS: quarter_turns_q <= cfg_data_i[TURNS_W-1:0];
        CFG_ZOOM_Q8:       zoom_q8_q       <= cfg_data_i[ZOOM_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective tile size 1..32, zoom at least 1, and the rounded zoomed size.
  always_comb begin
    if (tile_size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (tile_size_q > SIZE_W'(STORE_SIDE)) begin
      n_eff = SIZE_W'(STORE_SIDE);
    end else begin
      n_eff = tile_size_q;
    end
    z_eff    = (zoom_q8_q == '0) ? ZOOM_W'(1) : zoom_q8_q;
    prod     = PROD_W'(n_eff) * PROD_W'(z_eff) + PROD_W'(ROUND_HALF);
    size_raw = prod[PROD_W-1:FRAC_W];

    cfg.last_idx = COORD_W'(n_eff - SIZE_W'(1));
    cfg.zoom     = z_eff;
    cfg.turns    = quarter_turns_q;
    cfg.out_size = (size_raw > RAW_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : size_raw[SIZE_W-1:0];
  end

  // Front classifies against the live config and queues up to two items.
  trz_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .pop_i      (mid_pop),
    .head_o     (mid_head),
    .head_vld_o (mid_vld)
  );

  // Back runs free; it only takes a read when a result slot is reserved.
  trz_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .head_i     (mid_head),
    .head_vld_i (mid_vld),
    .pop_o      (mid_pop),
    .out_pop_i  (out_pop),
    .res_push_o (res_push),
    .res_o      (res_item)
  );

  assign out_pop = pop && !empty;

  trz_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .item_i  (res_item),
    .pop_i   (pop),
    .empty_o (empty),
    .full_o  (outq_full),
    .item_o  (res_item_o)
  );

  // The credit scheme must keep the result queue from overflowing.
  a_no_outq_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!outq_full || out_pop))
    else $error("result pushed into full result queue");

  // An accepted item is waiting in the mid queue on the next cycle.
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> mid_vld)
    else $error("accepted item missing from mid queue");

  // The back only takes items that exist.
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> mid_vld)
    else $error("back popped an empty mid queue");

endmodule

[hw/rtl/trz_front.sv]
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on trz_pkg.
module trz_front import trz_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      push_i,
  input  in_item_t  item_i,
  output logic      full_o,
  input  logic      pop_i,
  output mid_item_t head_o,
  output logic      head_vld_o
);

  mid_item_t              mq_q [MID_DEPTH];
  mid_item_t              cls;
  logic [MID_AW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [MID_CNT_W-1:0]   cnt_q, cnt_d;
  logic                   acc, pop;

  // Quotient of row*256/zoom reaches 2^DIV_STEPS exactly when row*2^(8-5) >= zoom.
  always_comb begin
    cls.req_type = item_i.req_type;
    cls.row      = item_i.row;
    cls.col      = item_i.col;
    cls.pixel    = item_i.pixel_in;
    cls.ovf_r    = (ZOOM_W'(item_i.row) << (FRAC_W - DIV_STEPS)) >= cfg_i.zoom;
    cls.ovf_c    = (ZOOM_W'(item_i.col) << (FRAC_W - DIV_STEPS)) >= cfg_i.zoom;
    cls.in_range = (SIZE_W'(item_i.row) < cfg_i.out_size) &&
                   (SIZE_W'(item_i.col) < cfg_i.out_size);
    cls.out_size = cfg_i.out_size;
  end

  assign full_o     = (cnt_q == MID_CNT_W'(MID_DEPTH));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mq_q[rd_ptr_q];
  assign acc        = push_i && !full_o;
  assign pop        = pop_i && head_vld_o;

  always_comb begin
    wr_ptr_d = acc ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (acc && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !acc) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mq_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[hw/rtl/trz_back.sv]
// Back end: pipelined zoom divider, rotation mapping and the pixel store.
// Depends on trz_pkg. Issues reads only against free result queue slots.
module trz_back import trz_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  mid_item_t head_i,
  input  logic      head_vld_i,
  output logic      pop_o,
  input  logic      out_pop_i,
  output logic      res_push_o,
  output res_item_t res_o
);

  typedef struct packed {
    req_type_e          req_type;
    logic [REM_W-1:0]   rem_r;
    logic [REM_W-1:0]   rem_c;
    logic [COORD_W-1:0] q_r;
    logic [COORD_W-1:0] q_c;
    logic               ovf_r;
    logic               ovf_c;
    logic               in_range;
    logic [SIZE_W-1:0]  out_size;
    logic [PIX_W-1:0]   pixel;
  } div_t;

  typedef struct packed {
    req_type_e         req_type;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pixel;
    logic              in_range;
    logic [SIZE_W-1:0] out_size;
  } acc_t;

  // One restoring step on both coordinates, quotient bits MSB first.
  // Loads pass through untouched so their row and col survive in rem_r/rem_c.
  function automatic div_t div_step(div_t s, logic [ZOOM_W-1:0] z, int unsigned sh);
    div_t              o;
    logic [DIVR_W-1:0] d;
    o = s;
    d = DIVR_W'(z) << sh;
    if (s.req_type == REQ_READ) begin
      if (DIVR_W'(s.rem_r) >= d) begin
        o.rem_r = s.rem_r - d[REM_W-1:0];
        o.q_r   = {s.q_r[COORD_W-2:0], 1'b1};
      end else begin
        o.q_r   = {s.q_r[COORD_W-2:0], 1'b0};
      end
      if (DIVR_W'(s.rem_c) >= d) begin
        o.rem_c = s.rem_c - d[REM_W-1:0];
        o.q_c   = {s.q_c[COORD_W-2:0], 1'b1};
      end else begin
        o.q_c   = {s.q_c[COORD_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  logic [OUTQ_CNT_W-1:0] reserved_q, reserved_d;
  logic                  credit_ok, rd_take;

  div_t                  div_in [DIV_STEPS];
  div_t                  div_d  [DIV_STEPS];
  div_t                  div_q  [DIV_STEPS];
  logic [DIV_STEPS-1:0]  div_vld_q;

  div_t                  last;
  logic [COORD_W-1:0]    a, b, sr, sc;
  acc_t                  ac_d, ac_q;
  logic                  ac_vld_q;

  logic [PIX_W-1:0]      pixel_store_q [STORE_DEPTH];
  logic [PIX_W-1:0]      rd_data_q;
  logic                  rs_vld_q;
  logic                  rs_inr_q;
  logic [SIZE_W-1:0]     rs_size_q;

  // Credit: reads in flight plus results waiting never exceed the queue depth.
  assign credit_ok = (reserved_q < OUTQ_CNT_W'(OUTQ_DEPTH));
  assign pop_o     = head_vld_i && ((head_i.req_type == REQ_LOAD) || credit_ok);
  assign rd_take   = pop_o && (head_i.req_type == REQ_READ);

  always_comb begin
    reserved_d = reserved_q;
    case ({rd_take, out_pop_i})
      2'b10:   reserved_d = reserved_q + 1'b1;
      2'b01:   reserved_d = reserved_q - 1'b1;
      default: reserved_d = reserved_q;
    endcase
  end

  always_comb begin
    div_in[0].req_type = head_i.req_type;
    div_in[0].rem_r    = {head_i.row, {FRAC_W{1'b0}}};
    div_in[0].rem_c    = {head_i.col, {FRAC_W{1'b0}}};
    div_in[0].q_r      = '0;
    div_in[0].q_c      = '0;
    div_in[0].ovf_r    = head_i.ovf_r;
    div_in[0].ovf_c    = head_i.ovf_c;
    div_in[0].in_range = head_i.in_range;
    div_in[0].out_size = head_i.out_size;
    div_in[0].pixel    = head_i.pixel;
    for (int k = 1; k < DIV_STEPS; k++) begin
      div_in[k] = div_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_d[k] = div_step(div_in[k], cfg_i.zoom, DIV_STEPS - 1 - k);
    end
  end

  // Clamp to the tile, then undo the rotation by index mapping.
  always_comb begin
    last = div_q[DIV_STEPS-1];
    a = (last.ovf_r || (last.q_r > cfg_i.last_idx)) ? cfg_i.last_idx : last.q_r;
    b = (last.ovf_c || (last.q_c > cfg_i.last_idx)) ? cfg_i.last_idx : last.q_c;
    unique case (cfg_i.turns)
      2'd1: begin
        sr = cfg_i.last_idx - b;
        sc = a;
      end
      2'd2: begin
        sr = cfg_i.last_idx - a;
        sc = cfg_i.last_idx - b;
      end
      2'd3: begin
        sr = b;
        sc = cfg_i.last_idx - a;
      end
      default: begin
        sr = a;
        sc = b;
      end
    endcase
    ac_d.req_type = last.req_type;
    ac_d.addr     = (last.req_type == REQ_LOAD) ? {last.rem_r[REM_W-1:FRAC_W],
                                                   last.rem_c[REM_W-1:FRAC_W]}
                                                : {sr, sc};
    ac_d.pixel    = last.pixel;
    ac_d.in_range = last.in_range;
    ac_d.out_size = last.out_size;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
      div_vld_q  <= '0;
      ac_vld_q   <= 1'b0;
      rs_vld_q   <= 1'b0;
    end else begin
      reserved_q <= reserved_d;
      div_vld_q  <= {div_vld_q[DIV_STEPS-2:0], pop_o};
      ac_vld_q   <= div_vld_q[DIV_STEPS-1];
      rs_vld_q   <= ac_vld_q && (ac_q.req_type == REQ_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_q[k] <= div_d[k];
    end
    ac_q      <= ac_d;
    rs_inr_q  <= ac_q.in_range;
    rs_size_q <= ac_q.out_size;
  end

  // Loads and reads meet the store at the same stage, so item order holds.
  always_ff @(posedge clk_i) begin
    if (ac_vld_q) begin
      if (ac_q.req_type == REQ_LOAD) begin
        pixel_store_q[ac_q.addr] <= ac_q.pixel;
      end else begin
        rd_data_q <= pixel_store_q[ac_q.addr];
      end
    end
  end

  assign res_push_o      = rs_vld_q;
  assign res_o.pixel_out = rs_inr_q ? rd_data_q : '0;
  assign res_o.in_range  = rs_inr_q;
  assign res_o.out_size  = rs_size_q;

endmodule

[hw/rtl/trz_out_queue.sv]
// Result queue: holds finished results until the consumer pops them.
// Depends on trz_pkg.
module trz_out_queue import trz_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  res_item_t item_i,
  input  logic      pop_i,
  output logic      empty_o,
  output logic      full_o,
  output res_item_t item_o
);

  res_item_t             rq_q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [OUTQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == OUTQ_CNT_W'(OUTQ_DEPTH));
  assign item_o  = rq_q[rd_ptr_q];
  assign pop     = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      rq_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[dv/tb_tile_rotate_and_nearest_zoom_top.sv]
// Self-checking testbench for tile_rotate_and_nearest_zoom_top: queue-style item and
// result ports, random idling on both sides, in-order compare against a built-in predictor.
// Depends on trz_pkg and the top-level RTL only.
module tb_tile_rotate_and_nearest_zoom_top;
  import trz_pkg::*;

  // Spare register index: writes there must leave the block untouched.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  // Padding after the last result so that in-flight loads reach the store; pad generously.
  localparam int DRAIN_CYCLES   = 16;
  localparam int QUIET_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 100;
  localparam int RANDOM_PHASES  = 11;
  localparam int CALM_PHASE     = 4;
  localparam int IDLE_PCT       = 7;
  localparam int MAX_ERR_LINES  = 100;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  res_item_t res_item_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  tile_rotate_and_nearest_zoom_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .res_item_o (res_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: configuration as written, pixel store as loaded.
  logic [SIZE_W-1:0]  cfg_tile  = 6'd32;
  logic [TURNS_W-1:0] cfg_turns = 2'd0;
  logic [ZOOM_W-1:0]  cfg_zoom  = 12'd256;
  logic [PIX_W-1:0]   shadow_store [STORE_DEPTH];
  // Addresses the stimulus has loaded so far; an in-range read of any other entry gets a load first.
  bit                 loaded [STORE_DEPTH];

  in_item_t  item_backlog  [$];
  res_item_t predicted_res [$];
  int n_queued = 0;
  int n_taken  = 0;
  int n_errors = 0;
  int err_lines = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  // Output (r,c) -> zoom back to rotated coords -> undo the clockwise turns.
  // Returns the in-range flag; addr is the store entry, sz the zoomed side.
  function automatic logic map_to_source(input logic [COORD_W-1:0] r,
                                         input logic [COORD_W-1:0] c,
                                         output logic [ADDR_W-1:0] addr,
                                         output logic [SIZE_W-1:0] sz);
    int unsigned n, z, s, a, b, sr, sc;
    n = (cfg_tile == 0) ? 1 : ((cfg_tile > STORE_SIDE) ? STORE_SIDE : cfg_tile);
    z = (cfg_zoom == 0) ? 1 : cfg_zoom;
    s = (n * z + (1 << (FRAC_W - 1))) >> FRAC_W;
    if (s > MAX_DIM) s = MAX_DIM;
    a = (int'(r) << FRAC_W) / z;
    b = (int'(c) << FRAC_W) / z;
    if (a > n - 1) a = n - 1;
    if (b > n - 1) b = n - 1;
    case (cfg_turns)
      2'd1: begin
        sr = n - 1 - b;
        sc = a;
      end
      2'd2: begin
        sr = n - 1 - a;
        sc = n - 1 - b;
      end
      2'd3: begin
        sr = b;
        sc = n - 1 - a;
      end
      default: begin
        sr = a;
        sc = b;
      end
    endcase
    addr = ADDR_W'((sr % STORE_SIDE) * STORE_SIDE + (sc % STORE_SIDE));
    sz = SIZE_W'(s);
    return (r < s) && (c < s);
  endfunction

  // Runs one accepted item through the shadow; reads leave one expected result.
  function automatic void predict_item(input in_item_t it);
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] sz;
    res_item_t r;
    if (it.req_type == REQ_LOAD) begin
      shadow_store[{it.row, it.col}] = it.pixel_in;
    end else begin
      r.in_range = map_to_source(it.row, it.col, addr, sz);
      r.out_size = sz;
      r.pixel_out = r.in_range ? shadow_store[addr] : '0;
      predicted_res.push_back(r);
    end
  endfunction

  // Appends an item; an in-range read of a never-loaded entry gets a load first.
  function automatic void queue_item(input in_item_t it);
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] sz;
    in_item_t fill;
    if (it.req_type == REQ_READ && map_to_source(it.row, it.col, addr, sz) && !loaded[addr]) begin
      fill.req_type = REQ_LOAD;
      fill.row = addr[ADDR_W-1:COORD_W];
      fill.col = addr[COORD_W-1:0];
      fill.pixel_in = PIX_W'($urandom);
      loaded[addr] = 1'b1;
      item_backlog.push_back(fill);
      n_queued++;
    end
    if (it.req_type == REQ_LOAD) loaded[{it.row, it.col}] = 1'b1;
    item_backlog.push_back(it);
    n_queued++;
  endfunction

  function automatic void queue_load(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c,
                                     input logic [PIX_W-1:0] p);
    in_item_t it;
    it.req_type = REQ_LOAD;
    it.row = r;
    it.col = c;
    it.pixel_in = p;
    queue_item(it);
  endfunction

  function automatic void queue_read(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
    in_item_t it;
    it.req_type = REQ_READ;
    it.row = r;
    it.col = c;
    it.pixel_in = PIX_W'($urandom);  // don't-care on reads, toggle it anyway
    queue_item(it);
  endfunction

  function automatic void read_corners();
    queue_read('0, '0);
    queue_read('0, '1);
    queue_read('1, '0);
    queue_read('1, '1);
  endfunction

  // Sender holds until every item is taken and every result is back,
  // then lets in-flight loads (no result) retire.
  task automatic wait_drained();
    while (n_taken != n_queued || predicted_res.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_TILE_SIZE:     cfg_tile  = data[SIZE_W-1:0];
      CFG_QUARTER_TURNS: cfg_turns = data[TURNS_W-1:0];
      CFG_ZOOM_Q8:       cfg_zoom  = data[ZOOM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [SIZE_W-1:0] tile, input logic [TURNS_W-1:0] turns,
                            input logic [ZOOM_W-1:0] zoom);
    wait_drained();
    write_reg(CFG_TILE_SIZE, CFG_DATA_W'(tile));
    write_reg(CFG_QUARTER_TURNS, CFG_DATA_W'(turns));
    write_reg(CFG_ZOOM_Q8, CFG_DATA_W'(zoom));
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: push holds its item until taken; new item or idle chosen when the slot frees.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_item(in_item_i);
        n_taken++;
      end
      if (!push || !full) begin
        if (item_backlog.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          push      <= 1'b1;
          in_item_i <= item_backlog.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each taken result with the oldest prediction; watchdog on progress.
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (predicted_res.size() == 0) begin
          n_errors++;
          if (err_lines < MAX_ERR_LINES) begin
            $display("%0t: result with none expected, expected none actual %p", $time,
                     res_item_o);
            err_lines++;
          end
        end else begin
          want = predicted_res.pop_front();
          if (res_item_o != want) begin
            n_errors++;
            if (res_item_o.pixel_out != want.pixel_out && err_lines < MAX_ERR_LINES) begin
              $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel_out,
                       res_item_o.pixel_out);
              err_lines++;
            end
            if (res_item_o.in_range != want.in_range && err_lines < MAX_ERR_LINES) begin
              $display("%0t: in_range expected %0d actual %0d", $time, want.in_range,
                       res_item_o.in_range);
              err_lines++;
            end
            if (res_item_o.out_size != want.out_size && err_lines < MAX_ERR_LINES) begin
              $display("%0t: out_size expected %0d actual %0d", $time, want.out_size,
                       res_item_o.out_size);
              err_lines++;
            end
          end
        end
      end
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tile_rotate_and_nearest_zoom_top: mismatch");
        $finish;
      end
      pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    logic [SIZE_W-1:0]  tile;
    logic [TURNS_W-1:0] turns;
    logic [ZOOM_W-1:0]  zoom;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  sz;
    int                 phase_end;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset configuration first, extreme pixels at the tile corners.
    queue_load('0, '0, 8'h00);
    queue_load('1, '1, 8'hFF);
    queue_load('0, '1, 8'hAA);
    queue_load('1, '0, 8'h55);
    read_corners();
    // Each turn count; small tile (reads past the zoomed side), one-pixel tile with max
    // zoom, size and zoom of zero, oversized tile field, clamp of the zoomed side.
    set_config(6'd5, 2'd1, 12'd256);
    read_corners();
    set_config(6'd1, 2'd2, 12'd4095);
    read_corners();
    set_config(6'd0, 2'd3, 12'd0);
    read_corners();
    set_config(6'd63, 2'd1, 12'd4095);
    read_corners();
    set_config(6'd32, 2'd3, 12'd128);
    read_corners();

    // Random phases; each boundary holds the sender until all results are back.
    // Fill loads count toward the phase, so the item total stays near the target.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(9))
        0:       tile = 6'd1;
        1:       tile = 6'd32;
        2:       tile = SIZE_W'($urandom_range(33, 63));
        3:       tile = 6'd0;
        default: tile = SIZE_W'($urandom_range(1, 32));
      endcase
      case ($urandom_range(9))
        0:       zoom = 12'd4095;
        1:       zoom = 12'd1;
        2:       zoom = ZOOM_W'($urandom_range(1, 4095));
        default: zoom = ZOOM_W'($urandom_range(64, 1024));
      endcase
      turns = TURNS_W'($urandom_range(3));
      set_config(tile, turns, zoom);
      no_idle = (p == CALM_PHASE);
      void'(map_to_source('0, '0, addr, sz));
      phase_end = n_queued + PHASE_ITEMS;
      while (n_queued < phase_end) begin
        if ($urandom_range(99) < 35) begin
          queue_load(COORD_W'($urandom), COORD_W'($urandom), PIX_W'($urandom));
        end else if (sz != 0 && $urandom_range(99) < 80) begin
          // mostly inside the zoomed image, where the mapping does real work
          queue_read(COORD_W'($urandom_range(sz - 1)), COORD_W'($urandom_range(sz - 1)));
        end else begin
          queue_read(COORD_W'($urandom), COORD_W'($urandom));
        end
      end
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("tile_rotate_and_nearest_zoom_top: match");
    end else begin
      $display("tile_rotate_and_nearest_zoom_top: mismatch");
    end
    $finish;
  end

endmodule
